### rtl/core/sawt_pkg.sv
// Package with shared types and constants of the sequence/ack window tracker.
`default_nettype none
package sawt_pkg;

  localparam int SEQ_W  = 24;
  localparam int SESS_W = 8;
  localparam int MASK_W = 64;
  localparam int STS_W  = 3;

  typedef enum logic [1:0] {
    OP_INCOMING = 2'd0,
    OP_OUTGOING = 2'd1,
    OP_NOACK    = 2'd2,
    OP_CLEAR    = 2'd3
  } op_t;

  typedef enum logic [STS_W-1:0] {
    STS_OK          = 3'd0,
    STS_BAD_SESSION = 3'd1,
    STS_BAD_SEQ     = 3'd2,
    STS_FATAL_GAP   = 3'd3,
    STS_NOT_CONN    = 3'd4,
    STS_TABLE_FULL  = 3'd5
  } sts_t;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_NOTE   = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CMP,
    S_NOTE,
    S_STATUS
  } state_t;

  // Receive-window status handed from the window unit to the controller
  typedef struct packed {
    logic             seq_ok;
    logic             any;
    logic [SEQ_W-1:0] last;
  } rxw_stat_t;

endpackage
`default_nettype wire

### rtl/core/seq_ack_window_tracker.sv
// Top level: connection tracker with in-flight table kept in a RAM.
// Each word on the input channel yields zero or more notification words and
// then one status word. Outgoing requests, do-not-ack marking and clear
// go from acceptance straight to the status state, but an outgoing
// request on a full table walks first. An incoming header whose ack covers
// n sequences, n at most ACK_WIDTH, walks them one at a time; for each it
// scans the in-flight table in slot order, skipping free slots and reading
// each used slot from RAM and then comparing it, stopping at the first used
// match. A full table on an outgoing request walks FLIGHT_DEPTH sequences
// the same way. Output stalls hold the notification and status words; the
// input is stalled while a word is in progress. The flight sequence RAM
// needs no clearing after reset.
`default_nettype none
module seq_ack_window_tracker #(
  parameter int ACK_WIDTH    = 64,
  parameter int FLIGHT_DEPTH = 32,
  parameter int RX_WINDOW    = 128
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [sawt_pkg::SESS_W-1:0]   cfg_wr_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    in_operation,
  input  wire logic [sawt_pkg::SESS_W-1:0]   in_hdr_session,
  input  wire logic [sawt_pkg::SEQ_W-1:0]    in_hdr_seq,
  input  wire logic                          in_hdr_ack_valid,
  input  wire logic [sawt_pkg::SEQ_W-1:0]    in_hdr_highest_ack,
  input  wire logic [sawt_pkg::MASK_W-1:0]   in_hdr_ack_mask,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_kind,
  output logic [sawt_pkg::STS_W-1:0]         out_status,
  output logic [sawt_pkg::SEQ_W-1:0]         out_seq,
  output logic                               out_acked,
  output logic                               out_rx_seq_valid,
  output logic [sawt_pkg::SEQ_W-1:0]         out_rx_seq,
  output logic [sawt_pkg::MASK_W-1:0]        out_rx_bitmap,
  output logic                               out_connected,
  output logic                               out_last
);
  import sawt_pkg::*;

  localparam int PW     = $clog2(FLIGHT_DEPTH);
  localparam int AIDX_W = $clog2(ACK_WIDTH);
  localparam int CNT_W  = (AIDX_W > PW) ? AIDX_W : PW;

  state_t               state_r, state_nxt;
  logic [SESS_W-1:0]    session_r;
  logic [SEQ_W-1:0]     tx_last_r, tx_last_nxt;
  logic                 tx_any_r, tx_any_nxt;
  logic [SEQ_W-1:0]     peer_upto_r, peer_upto_nxt;
  logic                 peer_any_r, peer_any_nxt;
  logic                 link_up_r, link_up_nxt;
  logic [FLIGHT_DEPTH-1:0] used_r, used_nxt;
  logic [FLIGHT_DEPTH-1:0] noack_r, noack_nxt;
  logic [SEQ_W-1:0]     cur_r, cur_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [PW-1:0]        p_r, p_nxt;
  logic                 full_r, full_nxt;
  logic [ACK_WIDTH-1:0] mask_r, mask_nxt;
  sts_t                 res_sts_r, res_sts_nxt;
  logic [SEQ_W-1:0]     res_seq_r, res_seq_nxt;
  logic                 res_rx_r, res_rx_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_kind_r, out_kind_nxt;
  logic [STS_W-1:0]     out_status_r, out_status_nxt;
  logic [SEQ_W-1:0]     out_seq_r, out_seq_nxt;
  logic                 out_acked_r, out_acked_nxt;
  logic                 out_rxv_r, out_rxv_nxt;
  logic [SEQ_W-1:0]     out_rxs_r, out_rxs_nxt;
  logic [MASK_W-1:0]    out_rxb_r, out_rxb_nxt;
  logic                 out_conn_r, out_conn_nxt;
  logic                 out_last_r, out_last_nxt;

  rxw_stat_t            rx_stat;
  logic [ACK_WIDTH-1:0] rx_bits;
  logic                 rx_upd, rx_clr;
  logic                 ram_we;
  logic [PW-1:0]        ram_waddr;
  logic [SEQ_W-1:0]     ram_wdata;
  logic [SEQ_W-1:0]     ram_rdata;

  logic                 in_acc;
  logic                 out_free;
  logic                 last_slot, last_seq;
  logic                 free_found;
  logic [PW-1:0]        free_slot;
  logic [SEQ_W:0]       start_x, high_x, span;
  logic                 span_ok, fatal;
  logic [SEQ_W-1:0]     full_start;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign last_slot = (p_r == PW'(FLIGHT_DEPTH - 1));
  assign last_seq  = (cnt_r == '0);

  sawt_rxwin #(.ACK_WIDTH(ACK_WIDTH), .RX_WINDOW(RX_WINDOW)) u_rxwin (
    .clk    (clk),
    .rst_n  (rst_n),
    .hdr_seq(in_hdr_seq),
    .upd    (rx_upd),
    .clr    (rx_clr),
    .stat   (rx_stat),
    .bits   (rx_bits)
  );

  sawt_ram #(.WIDTH(SEQ_W), .DEPTH(FLIGHT_DEPTH)) u_flight (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(p_r),
    .rdata(ram_rdata)
  );

  // Find lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = FLIGHT_DEPTH - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_found = 1'b1;
        free_slot  = PW'(i);
      end
    end
  end

  // Ack span to resolve and fatal-gap check
  always_comb begin
    start_x    = peer_any_r ? ({1'b0, peer_upto_r} + (SEQ_W+1)'(1)) : '0;
    high_x     = {1'b0, in_hdr_highest_ack};
    span       = high_x - start_x;
    span_ok    = (start_x <= high_x);
    fatal      = span_ok && (span >= (SEQ_W+1)'(ACK_WIDTH));
    full_start = peer_any_r ? (peer_upto_r + SEQ_W'(1)) : '0;
  end

  // Sequencer: accept word, walk sequences, emit words
  always_comb begin
    state_nxt     = state_r;
    tx_last_nxt   = tx_last_r;
    tx_any_nxt    = tx_any_r;
    peer_upto_nxt = peer_upto_r;
    peer_any_nxt  = peer_any_r;
    link_up_nxt   = link_up_r;
    used_nxt      = used_r;
    noack_nxt     = noack_r;
    cur_nxt       = cur_r;
    cnt_nxt       = cnt_r;
    p_nxt         = p_r;
    full_nxt      = full_r;
    mask_nxt      = mask_r;
    res_sts_nxt   = res_sts_r;
    res_seq_nxt   = res_seq_r;
    res_rx_nxt    = res_rx_r;
    rx_upd        = 1'b0;
    rx_clr        = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = free_slot;
    ram_wdata     = tx_any_r ? (tx_last_r + SEQ_W'(1)) : '0;

    out_valid_nxt  = out_valid_r && out_stall;
    out_kind_nxt   = out_kind_r;
    out_status_nxt = out_status_r;
    out_seq_nxt    = out_seq_r;
    out_acked_nxt  = out_acked_r;
    out_rxv_nxt    = out_rxv_r;
    out_rxs_nxt    = out_rxs_r;
    out_rxb_nxt    = out_rxb_r;
    out_conn_nxt   = out_conn_r;
    out_last_nxt   = out_last_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          res_sts_nxt = STS_OK;
          res_seq_nxt = '0;
          res_rx_nxt  = 1'b0;
          state_nxt   = S_STATUS;
          case (op_t'(in_operation))
            OP_INCOMING: begin
              if (in_hdr_session != session_r) begin
                res_sts_nxt = STS_BAD_SESSION;
              end else if (!rx_stat.seq_ok) begin
                res_sts_nxt = STS_BAD_SEQ;
              end else begin
                rx_upd = 1'b1;
                if (in_hdr_ack_valid) begin
                  if (fatal) begin
                    link_up_nxt = 1'b0;
                    res_sts_nxt = STS_FATAL_GAP;
                  end else begin
                    peer_upto_nxt = in_hdr_highest_ack;
                    peer_any_nxt  = 1'b1;
                    if (span_ok) begin
                      cur_nxt   = start_x[SEQ_W-1:0];
                      cnt_nxt   = span[CNT_W-1:0];
                      p_nxt     = '0;
                      full_nxt  = 1'b0;
                      mask_nxt  = in_hdr_ack_mask[ACK_WIDTH-1:0];
                      state_nxt = S_SCAN;
                    end
                  end
                end
              end
            end
            OP_OUTGOING: begin
              if (!link_up_r) begin
                res_sts_nxt = STS_NOT_CONN;
              end else if (free_found) begin
                ram_we               = 1'b1;
                tx_last_nxt          = ram_wdata;
                tx_any_nxt           = 1'b1;
                used_nxt[free_slot]  = 1'b1;
                noack_nxt[free_slot] = 1'b0;
                res_seq_nxt          = ram_wdata;
                res_rx_nxt           = 1'b1;
              end else begin
                // Table full: report the next window of sequences lost
                cur_nxt       = full_start;
                cnt_nxt       = CNT_W'(FLIGHT_DEPTH - 1);
                p_nxt         = '0;
                full_nxt      = 1'b1;
                peer_upto_nxt = full_start + SEQ_W'(FLIGHT_DEPTH - 1);
                peer_any_nxt  = 1'b1;
                link_up_nxt   = 1'b0;
                res_sts_nxt   = STS_TABLE_FULL;
                state_nxt     = S_SCAN;
              end
            end
            OP_NOACK: begin
              noack_nxt = noack_r | used_r;
            end
            OP_CLEAR: begin
              rx_clr        = 1'b1;
              tx_last_nxt   = '0;
              tx_any_nxt    = 1'b0;
              peer_upto_nxt = '0;
              peer_any_nxt  = 1'b0;
              link_up_nxt   = 1'b1;
              used_nxt      = '0;
              noack_nxt     = '0;
            end
            default: begin
              res_sts_nxt = STS_OK;
            end
          endcase
        end
      end

      S_SCAN: begin
        // Read used slots, skip free ones
        if (used_r[p_r]) begin
          state_nxt = S_CMP;
        end else if (!last_slot) begin
          p_nxt = p_r + PW'(1);
        end else if (last_seq) begin
          state_nxt = S_STATUS;
        end else begin
          cur_nxt = cur_r + SEQ_W'(1);
          cnt_nxt = cnt_r - CNT_W'(1);
          p_nxt   = '0;
        end
      end

      S_CMP: begin
        if (ram_rdata == cur_r) begin
          if (!noack_r[p_r]) begin
            state_nxt = S_NOTE;
          end else if (last_seq) begin
            state_nxt = S_STATUS;
          end else begin
            cur_nxt   = cur_r + SEQ_W'(1);
            cnt_nxt   = cnt_r - CNT_W'(1);
            p_nxt     = '0;
            state_nxt = S_SCAN;
          end
        end else if (!last_slot) begin
          p_nxt     = p_r + PW'(1);
          state_nxt = S_SCAN;
        end else if (last_seq) begin
          state_nxt = S_STATUS;
        end else begin
          cur_nxt   = cur_r + SEQ_W'(1);
          cnt_nxt   = cnt_r - CNT_W'(1);
          p_nxt     = '0;
          state_nxt = S_SCAN;
        end
      end

      S_NOTE: begin
        // Emit notification word and release the slot
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = KIND_NOTE;
          out_status_nxt = STS_OK;
          out_seq_nxt    = cur_r;
          out_acked_nxt  = !full_r && mask_r[cnt_r[AIDX_W-1:0]];
          out_rxv_nxt    = 1'b0;
          out_rxs_nxt    = '0;
          out_rxb_nxt    = '0;
          out_conn_nxt   = link_up_r;
          out_last_nxt   = 1'b0;
          used_nxt[p_r]  = 1'b0;
          if (last_seq) begin
            state_nxt = S_STATUS;
          end else begin
            cur_nxt   = cur_r + SEQ_W'(1);
            cnt_nxt   = cnt_r - CNT_W'(1);
            p_nxt     = '0;
            state_nxt = S_SCAN;
          end
        end
      end

      S_STATUS: begin
        // Emit closing status word
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = KIND_STATUS;
          out_status_nxt = res_sts_r;
          out_seq_nxt    = res_seq_r;
          out_acked_nxt  = 1'b0;
          out_rxv_nxt    = res_rx_r && rx_stat.any;
          out_rxs_nxt    = (res_rx_r && rx_stat.any) ? rx_stat.last : '0;
          out_rxb_nxt    = res_rx_r ? MASK_W'(rx_bits) : '0;
          out_conn_nxt   = link_up_r;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      session_r   <= '0;
      tx_last_r   <= '0;
      tx_any_r    <= 1'b0;
      peer_upto_r <= '0;
      peer_any_r  <= 1'b0;
      link_up_r   <= 1'b1;
      used_r      <= '0;
      noack_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_wr_en) begin
        session_r <= cfg_wr_data;
      end
      tx_last_r   <= tx_last_nxt;
      tx_any_r    <= tx_any_nxt;
      peer_upto_r <= peer_upto_nxt;
      peer_any_r  <= peer_any_nxt;
      link_up_r   <= link_up_nxt;
      used_r      <= used_nxt;
      noack_r     <= noack_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Walk and result payload registers
  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    cnt_r        <= cnt_nxt;
    p_r          <= p_nxt;
    full_r       <= full_nxt;
    mask_r       <= mask_nxt;
    res_sts_r    <= res_sts_nxt;
    res_seq_r    <= res_seq_nxt;
    res_rx_r     <= res_rx_nxt;
    out_kind_r   <= out_kind_nxt;
    out_status_r <= out_status_nxt;
    out_seq_r    <= out_seq_nxt;
    out_acked_r  <= out_acked_nxt;
    out_rxv_r    <= out_rxv_nxt;
    out_rxs_r    <= out_rxs_nxt;
    out_rxb_r    <= out_rxb_nxt;
    out_conn_r   <= out_conn_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_status       = out_status_r;
  assign out_seq          = out_seq_r;
  assign out_acked        = out_acked_r;
  assign out_rx_seq_valid = out_rxv_r;
  assign out_rx_seq       = out_rxs_r;
  assign out_rx_bitmap    = out_rxb_r;
  assign out_connected    = out_conn_r;
  assign out_last         = out_last_r;

  a_clear_state: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_operation == OP_CLEAR |=> used_r == '0 && link_up_r)
    else $error("clear left table or link state behind");
  a_note_slot_used: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_NOTE |-> used_r[p_r] && !noack_r[p_r])
    else $error("notification for a free or do-not-ack slot");
  a_note_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r == KIND_NOTE |-> !out_last_r)
    else $error("notification word marked last");
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE && state_r != S_STATUS && !full_r
      |-> {1'b0, cnt_r} < (CNT_W+1)'(ACK_WIDTH))
    else $error("ack walk beyond bitmap width");

endmodule
`default_nettype wire

### rtl/core/sawt_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none
module sawt_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

### rtl/core/sawt_rxwin.sv
// Receive window: last received sequence, received bitmap and window check.
`default_nettype none
module sawt_rxwin #(
  parameter int ACK_WIDTH = 64,
  parameter int RX_WINDOW = 128
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic [sawt_pkg::SEQ_W-1:0] hdr_seq,
  input  wire logic                    upd,
  input  wire logic                    clr,
  output sawt_pkg::rxw_stat_t          stat,
  output logic      [ACK_WIDTH-1:0]    bits
);
  import sawt_pkg::*;

  localparam int SH_W = $clog2(ACK_WIDTH);

  logic [SEQ_W-1:0]     last_r, last_nxt;
  logic                 any_r, any_nxt;
  logic [ACK_WIDTH-1:0] bits_r, bits_nxt;
  logic [SEQ_W:0]       last_x;
  logic [SEQ_W:0]       sh;
  logic                 ok;

  // Advance from last received; minus one while nothing received
  always_comb begin
    last_x = any_r ? {1'b0, last_r} : {(SEQ_W+1){1'b1}};
    sh     = {1'b0, hdr_seq} - last_x;
    ok     = (!any_r || (hdr_seq > last_r)) && (sh <= (SEQ_W+1)'(RX_WINDOW));
  end

  // Shift bitmap by the advance and mark the new packet
  always_comb begin
    last_nxt = last_r;
    any_nxt  = any_r;
    bits_nxt = bits_r;
    if (clr) begin
      last_nxt = '0;
      any_nxt  = 1'b0;
      bits_nxt = '1;
    end else if (upd) begin
      if (sh >= (SEQ_W+1)'(ACK_WIDTH)) begin
        bits_nxt = '0;
      end else begin
        bits_nxt = bits_r << sh[SH_W-1:0];
      end
      bits_nxt[0] = 1'b1;
      last_nxt    = hdr_seq;
      any_nxt     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= '0;
      any_r  <= 1'b0;
      bits_r <= '1;
    end else begin
      last_r <= last_nxt;
      any_r  <= any_nxt;
      bits_r <= bits_nxt;
    end
  end

  assign stat.seq_ok = ok;
  assign stat.any    = any_r;
  assign stat.last   = last_r;
  assign bits        = bits_r;

  a_clr_restores: assert property (@(posedge clk) disable iff (!rst_n)
    clr |=> !any_r && bits_r == '1)
    else $error("window clear did not restore reset state");
  a_upd_sets_bit0: assert property (@(posedge clk) disable iff (!rst_n)
    upd && !clr |=> any_r && bits_r[0] && last_r == $past(hdr_seq))
    else $error("window update lost the new packet");
  a_reject_bad: assert property (@(posedge clk) disable iff (!rst_n)
    any_r && hdr_seq <= last_r |-> !ok)
    else $error("stale sequence accepted");

endmodule
`default_nettype wire

### tb/tb_seq_ack_window_tracker.sv
// Self-checking testbench for the sequence/ack window tracker.
`default_nettype none
module tb_seq_ack_window_tracker;
  timeunit 1ns;
  timeprecision 1ps;
  import sawt_pkg::*;

  localparam int ACK_W     = 64;
  localparam int DEPTH     = 32;
  localparam int WIN       = 128;
  localparam int LIMIT     = 4000000;
  localparam int HOLD_AT   = 70;
  localparam int HOLD_LEN  = 400;
  localparam int PHASE_LEN = 15;

  typedef struct {
    op_t         op;
    logic [7:0]  sess;
    logic [23:0] seq;
    logic        ackv;
    logic [23:0] high;
    logic [63:0] mask;
  } hdr_word_t;

  typedef struct {
    logic        kind;
    logic [2:0]  status;
    logic [23:0] seq;
    logic        acked;
    logic        rxv;
    logic [23:0] rxs;
    logic [63:0] rxb;
    logic        conn;
    logic        last;
  } res_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_operation = '0;
  logic [7:0]  in_hdr_session = '0;
  logic [23:0] in_hdr_seq = '0;
  logic        in_hdr_ack_valid = 1'b0;
  logic [23:0] in_hdr_highest_ack = '0;
  logic [63:0] in_hdr_ack_mask = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_kind;
  logic [2:0]  out_status;
  logic [23:0] out_seq;
  logic        out_acked;
  logic        out_rx_seq_valid;
  logic [23:0] out_rx_seq;
  logic [63:0] out_rx_bitmap;
  logic        out_connected;
  logic        out_last;

  seq_ack_window_tracker dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_operation(in_operation), .in_hdr_session(in_hdr_session),
    .in_hdr_seq(in_hdr_seq), .in_hdr_ack_valid(in_hdr_ack_valid),
    .in_hdr_highest_ack(in_hdr_highest_ack), .in_hdr_ack_mask(in_hdr_ack_mask),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_kind(out_kind), .out_status(out_status), .out_seq(out_seq),
    .out_acked(out_acked), .out_rx_seq_valid(out_rx_seq_valid),
    .out_rx_seq(out_rx_seq), .out_rx_bitmap(out_rx_bitmap),
    .out_connected(out_connected), .out_last(out_last)
  );

  hdr_word_t hdr_backlog[$];
  res_word_t pending_results[$];
  res_word_t item_results[$];
  bit        failed = 0;
  bit        quiet = 0;
  int        taken_cnt = 0;
  int        cycles = 0;

  // tracker copy: session register and connection state
  logic [7:0]  trk_sess = '0;
  logic [23:0] trk_rx_last, trk_tx_last, trk_upto;
  logic        trk_rx_any, trk_tx_any, trk_upto_any, trk_link;
  logic [63:0] trk_bits;
  logic [23:0] trk_fseq[DEPTH];
  logic        trk_fused[DEPTH];
  logic        trk_fnoack[DEPTH];

  // stimulus-side view of the conversation
  int g_rx_next, g_tx_sent, g_acked;

  task automatic clear_tracker();
    trk_rx_last = '0; trk_rx_any = 0; trk_bits = '1;
    trk_tx_last = '0; trk_tx_any = 0;
    trk_upto = '0; trk_upto_any = 0; trk_link = 1;
    for (int p = 0; p < DEPTH; p++) begin
      trk_fseq[p] = '0; trk_fused[p] = 0; trk_fnoack[p] = 0;
    end
  endtask

  // release the lowest used slot holding s, unless it is marked do-not-ack
  task automatic release_seq(input logic [23:0] s, input logic rcv);
    int p;
    res_word_t r;
    p = -1;
    for (int i = 0; i < DEPTH; i++)
      if (p < 0 && trk_fused[i] && trk_fseq[i] == s) p = i;
    if (p < 0 || trk_fnoack[p]) return;
    r = '{KIND_NOTE, STS_OK, s, rcv, 1'b0, 24'd0, 64'd0, 1'b0, 1'b0};
    item_results.push_back(r);
    trk_fused[p] = 0;
  endtask

  // compute the words one accepted header or request produces
  task automatic predict_words(input hdr_word_t w);
    longint last, start, sh, hi;
    sts_t st;
    int p;
    logic [23:0] s, sseq, srxs;
    logic srxv;
    logic [63:0] srxb;
    res_word_t r;
    item_results.delete();
    st = STS_OK; sseq = '0; srxv = 0; srxs = '0; srxb = '0;
    case (w.op)
      OP_INCOMING: begin
        last = trk_rx_any ? longint'(trk_rx_last) : -1;
        if (w.sess != trk_sess) st = STS_BAD_SESSION;
        else if (longint'(w.seq) <= last || longint'(w.seq) > last + WIN) st = STS_BAD_SEQ;
        else begin
          sh = longint'(w.seq) - last;
          if (sh >= ACK_W) trk_bits = '0;
          else trk_bits = trk_bits << sh;
          trk_bits[0] = 1'b1;
          trk_rx_last = w.seq; trk_rx_any = 1;
          if (w.ackv) begin
            start = trk_upto_any ? longint'(trk_upto) + 1 : 0;
            hi = longint'(w.high);
            if (start <= hi && hi - start >= ACK_W) begin
              trk_link = 0; st = STS_FATAL_GAP;
            end else begin
              for (longint i = start; i <= hi; i++)
                release_seq(i[23:0], w.mask[int'(hi - i)]);
              trk_upto = w.high; trk_upto_any = 1;
            end
          end
        end
      end
      OP_OUTGOING: begin
        if (!trk_link) st = STS_NOT_CONN;
        else begin
          p = -1;
          for (int i = 0; i < DEPTH; i++)
            if (p < 0 && !trk_fused[i]) p = i;
          if (p < 0) begin
            // table full: sweep a table's worth of sequences as lost
            s = trk_upto_any ? trk_upto + 24'd1 : 24'd0;
            for (int k = 0; k < DEPTH; k++) begin
              release_seq(s, 1'b0);
              trk_upto = s;
              s = s + 24'd1;
            end
            trk_upto_any = 1; trk_link = 0; st = STS_TABLE_FULL;
          end else begin
            trk_tx_last = trk_tx_any ? trk_tx_last + 24'd1 : 24'd0;
            trk_tx_any = 1;
            trk_fseq[p] = trk_tx_last; trk_fused[p] = 1; trk_fnoack[p] = 0;
            sseq = trk_tx_last; srxv = trk_rx_any;
            srxs = trk_rx_any ? trk_rx_last : 24'd0; srxb = trk_bits;
          end
        end
      end
      OP_NOACK: begin
        for (int i = 0; i < DEPTH; i++)
          if (trk_fused[i]) trk_fnoack[i] = 1;
      end
      default: clear_tracker();
    endcase
    r = '{KIND_STATUS, st, sseq, 1'b0, srxv, srxs, srxb, 1'b0, 1'b0};
    item_results.push_back(r);
    foreach (item_results[k]) begin
      item_results[k].conn = trk_link;
      item_results[k].last = (k == item_results.size() - 1);
      pending_results.push_back(item_results[k]);
    end
  endtask

  function automatic bit field_ok(string name, logic [63:0] e, logic [63:0] a);
    if (e !== a) begin
      $error("%s: expected %0h, actual %0h", name, e, a);
      return 0;
    end
    return 1;
  endfunction

  // clock and run limit
  initial forever #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("seq_ack_window_tracker test failed");
      $finish;
    end
  end

  // input driver: predict on accept, then offer the next word or idle
  hdr_word_t cur;
  int        in_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_words(cur);
        taken_cnt <= taken_cnt + 1;
      end
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
          in_gap = $urandom_range(0, 12);
          in_valid <= 1'b0;
        end else if (hdr_backlog.size() > 0) begin
          cur = hdr_backlog.pop_front();
          in_operation <= cur.op;
          in_hdr_session <= cur.sess;
          in_hdr_seq <= cur.seq;
          in_hdr_ack_valid <= cur.ackv;
          in_hdr_highest_ack <= cur.high;
          in_hdr_ack_mask <= cur.mask;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output stall: random bursts plus one long hold-off
  int  hold_cnt = 0;
  int  st_gap = 0;
  bit  hold_done = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else if (!hold_done && taken_cnt >= HOLD_AT) begin
      hold_done = 1;
      hold_cnt = HOLD_LEN;
      out_stall <= 1'b1;
    end else if (st_gap > 0) begin
      st_gap--;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      st_gap = $urandom_range(0, 12);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result monitor: compare each word with the oldest expectation
  always @(posedge clk) begin
    res_word_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result word: kind %0d status %0d seq %0h",
               out_kind, out_status, out_seq);
        failed = 1;
      end else begin
        e = pending_results.pop_front();
        if (!(field_ok("kind", e.kind, out_kind) &
              field_ok("status", e.status, out_status) &
              field_ok("seq", e.seq, out_seq) &
              field_ok("acked", e.acked, out_acked) &
              field_ok("rx_seq_valid", e.rxv, out_rx_seq_valid) &
              field_ok("rx_seq", e.rxs, out_rx_seq) &
              field_ok("rx_bitmap", e.rxb, out_rx_bitmap) &
              field_ok("connected", e.conn, out_connected) &
              field_ok("last", e.last, out_last)))
          failed = 1;
      end
    end
  end

  task automatic add(input op_t op, input logic [7:0] sess, input logic [23:0] seq,
                     input logic ackv, input logic [23:0] high, input logic [63:0] mask);
    hdr_word_t w;
    w = '{op, sess, seq, ackv, high, mask};
    hdr_backlog.push_back(w);
    if (op == OP_CLEAR) begin
      g_rx_next = 0; g_tx_sent = 0; g_acked = -1;
    end
  endtask

  // wait until every word is sent and every result has come back
  task automatic drain();
    while (hdr_backlog.size() != 0 || in_valid || pending_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [7:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    trk_sess = v;
  endtask

  // mostly well-formed conversation with random content, some noise
  task automatic random_phase(input int n, input int out_pct);
    int r, seqv, hi, adv;
    logic [63:0] mask;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      mask = {$urandom, $urandom};
      if ($urandom_range(0, 9) == 0) mask = '1;
      if (r < 8) begin
        add(op_t'($urandom_range(0, 3)), 8'($urandom), 24'($urandom), 1'($urandom),
            24'($urandom), {$urandom, $urandom});
      end else if (r < 8 + out_pct) begin
        add(OP_OUTGOING, trk_sess, '0, 1'b0, '0, '0);
        g_tx_sent++;
      end else if (r < 94) begin
        r = $urandom_range(0, 99);
        if (r < 80) seqv = g_rx_next + $urandom_range(0, 3);
        else if (r < 90) seqv = g_rx_next + $urandom_range(60, 140);
        else seqv = g_rx_next - $urandom_range(1, 5);
        if (seqv < 0) seqv = 0;
        if (seqv >= g_rx_next) g_rx_next = seqv + 1;
        r = $urandom_range(0, 99);
        if (r < 5) hi = g_acked + $urandom_range(64, 300);
        else if (r < 10) hi = g_acked - $urandom_range(0, 4);
        else begin
          adv = g_tx_sent - 1 - g_acked;
          if (adv > 20) adv = 20;
          if (adv < 0) adv = 0;
          hi = g_acked + $urandom_range(0, adv);
        end
        if (hi < 0) hi = 0;
        if (hi > g_acked) g_acked = hi;
        add(OP_INCOMING, ($urandom_range(0, 11) == 0) ? 8'($urandom) : trk_sess,
            seqv[23:0], $urandom_range(0, 99) < 85, hi[23:0], mask);
      end else if (r < 97) begin
        add(OP_NOACK, 8'($urandom), 24'($urandom), 1'($urandom), 24'($urandom), mask);
      end else begin
        add(OP_CLEAR, 8'($urandom), 24'($urandom), 1'($urandom), 24'($urandom), mask);
      end
    end
  endtask

  initial begin
    clear_tracker();
    g_rx_next = 0; g_tx_sent = 0; g_acked = -1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: window edges, acks, do-not-ack, fatal gap, disconnect
    add(OP_INCOMING, 8'h00, 24'd0, 1'b0, 24'd0, 64'd0);
    add(OP_INCOMING, 8'h00, 24'd0, 1'b0, 24'd0, 64'd0);
    add(OP_INCOMING, 8'h01, 24'd1, 1'b0, 24'd0, 64'd0);
    add(OP_INCOMING, 8'h00, 24'd128, 1'b0, 24'd0, 64'd0);
    add(OP_INCOMING, 8'h00, 24'd257, 1'b0, 24'd0, 64'd0);
    add(OP_INCOMING, 8'h00, 24'd130, 1'b0, 24'd0, 64'd0);
    repeat (4) add(OP_OUTGOING, 8'h00, 24'd0, 1'b0, 24'd0, 64'd0);
    add(OP_INCOMING, 8'h00, 24'd131, 1'b1, 24'd2, 64'h5);
    add(OP_NOACK, 8'h00, 24'd0, 1'b0, 24'd0, 64'd0);
    add(OP_OUTGOING, 8'h00, 24'd0, 1'b0, 24'd0, 64'd0);
    add(OP_INCOMING, 8'h00, 24'd132, 1'b1, 24'd4, '1);
    add(OP_INCOMING, 8'h00, 24'd133, 1'b1, 24'd1, 64'd0);
    add(OP_INCOMING, 8'h00, 24'd134, 1'b1, 24'hFFFFFF, '1);
    add(OP_OUTGOING, 8'h00, 24'd0, 1'b0, 24'd0, 64'd0);
    add(OP_INCOMING, 8'h00, 24'd135, 1'b0, 24'd0, 64'd0);
    add(OP_INCOMING, 8'h00, 24'hFFFFFF, 1'b1, 24'hFFFFFF, '1);
    add(OP_INCOMING, 8'hFF, 24'd136, 1'b0, 24'd0, 64'd0);
    add(OP_CLEAR, 8'h00, 24'd0, 1'b0, 24'd0, 64'd0);
    add(OP_INCOMING, 8'h00, 24'd127, 1'b1, 24'd0, '1);
    add(OP_INCOMING, 8'h00, 24'd255, 1'b0, 24'd0, 64'd0);
    drain();

    // table fills up, then a random phase per session setting
    write_cfg(8'hFF);
    add(OP_CLEAR, 8'h00, 24'd0, 1'b0, 24'd0, 64'd0);
    repeat (33) add(OP_OUTGOING, 8'hFF, 24'd0, 1'b0, 24'd0, 64'd0);
    add(OP_CLEAR, 8'h00, 24'd0, 1'b0, 24'd0, 64'd0);
    random_phase(PHASE_LEN, 45);
    drain();

    write_cfg(8'h00);
    add(OP_CLEAR, 8'h00, 24'd0, 1'b0, 24'd0, 64'd0);
    random_phase(PHASE_LEN, 35);
    drain();

    write_cfg(8'h5A);
    add(OP_CLEAR, 8'h00, 24'd0, 1'b0, 24'd0, 64'd0);
    random_phase(PHASE_LEN, 35);
    drain();

    write_cfg(8'($urandom));
    quiet = 1;
    add(OP_CLEAR, 8'h00, 24'd0, 1'b0, 24'd0, 64'd0);
    random_phase(PHASE_LEN, 35);
    drain();
    repeat (20) @(posedge clk);

    if (!failed) begin
      $display("seq_ack_window_tracker test passed");
    end else begin
      $display("seq_ack_window_tracker test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
